[sv/maa_pkg.sv]
// ----------------------------------------------------------------------------
// maa_pkg
// Shared widths, codes and state types of the main-axis arrangement block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package maa_pkg;

  // Field widths
  localparam int SIZE_W    = 16;  // child size, container size, spacing
  localparam int MODE_W    = 3;
  localparam int CFG_W     = 16;  // widest configuration register
  localparam int CFG_IDX_W = 2;
  localparam int POS_W     = 28;  // signed position and internal offsets
  localparam int IDX_W     = 5;   // child index as presented on the output

  // Serial divider: one quotient bit per step over the full offset width
  localparam int DIV_STEPS = POS_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTAINER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING   = 2'd2;

  // Arrangement modes
  typedef enum logic [MODE_W-1:0] {
    MODE_START   = 3'd0,
    MODE_END     = 3'd1,
    MODE_CENTER  = 3'd2,
    MODE_BETWEEN = 3'd3,
    MODE_AROUND  = 3'd4,
    MODE_EVENLY  = 3'd5
  } mode_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,   // collect child sizes
    ST_PREP,   // room and spacing product
    ST_FREE,   // free space, start offset, divider setup
    ST_DIV,    // serial division of the room magnitude
    ST_GAP,    // apply quotient sign, derive start offset
    ST_FETCH,  // first store read
    ST_EMIT    // one position beat per cycle while the output is free
  } state_e;

endpackage

[sv/maa_if.sv]
// ----------------------------------------------------------------------------
// maa_in_if / maa_out_if
// Valid/ready channels for child sizes in and child positions out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface maa_in_if;
  logic                        valid;
  logic                        ready;
  logic [maa_pkg::SIZE_W-1:0]  child_size;
  logic                        last_child;

  modport source (output valid, child_size, last_child, input ready);
  modport sink   (input valid, child_size, last_child, output ready);
endinterface

interface maa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [maa_pkg::POS_W-1:0]  position;
  logic [maa_pkg::IDX_W-1:0]         child_index;
  logic                              final_flag;

  modport source (output valid, position, child_index, final_flag, input ready);
  modport sink   (input valid, position, child_index, final_flag, output ready);
endinterface

[sv/maa_ram.sv]
// ----------------------------------------------------------------------------
// maa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module maa_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/main_axis_arrangement_core.sv]
// ----------------------------------------------------------------------------
// main_axis_arrangement_core
// Flexbox-style placement of children along one axis.
//
// Child sizes arrive one beat per cycle and are kept in a small RAM with a
// count and a running total; a beat with last_child set closes the list.
// The block then stops taking beats, works out the free space (a spacing
// product and a subtract, in ST_PREP and ST_FREE), runs a shared restoring
// divider for the space-between/around/evenly modes (in ST_DIV, one quotient
// bit per step, then ST_GAP fixes the sign), reads the store once in ST_FETCH
// to prime the pipe and then emits one position beat per cycle, in child
// order, the last one flagged. New beats are taken again once the flagged
// beat is out; the output register is the only thing that stalls the emit
// loop. Items beyond MAX_CHILDREN are dropped from the list. The user must
// see that configuration is written only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module main_axis_arrangement_core #(
  parameter int MAX_CHILDREN = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [maa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [maa_pkg::CFG_W-1:0]         cfg_wdata_i,
  // channels
  maa_in_if.sink                            in_i,
  maa_out_if.source                         out_o
);

  localparam int SizeW  = maa_pkg::SIZE_W;
  localparam int PosW   = maa_pkg::POS_W;
  localparam int IdxW   = maa_pkg::IDX_W;
  localparam int StepW  = maa_pkg::STEP_W;
  localparam int CntW   = $clog2(MAX_CHILDREN + 1);
  localparam int AddrW  = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
  localparam int TotW   = SizeW + CntW;
  localparam int MulW   = SizeW + CntW;
  localparam int DvW    = CntW + 1;
  localparam int DvW1   = DvW + 1;

  // Configuration registers
  logic [maa_pkg::MODE_W-1:0] mode_q;
  logic [SizeW-1:0]           container_q;
  logic [SizeW-1:0]           spacing_q;

  // Control state
  maa_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [TotW-1:0]  total_q, total_d;
  logic             out_valid_q, out_valid_d;

  // Datapath registers
  logic [PosW-1:0]  room_q, room_d;
  logic [MulW-1:0]  mul_q, mul_d;
  logic [PosW-1:0]  gap_q, gap_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  quo_q, quo_d;
  logic [DvW-1:0]   rem_q, rem_d;
  logic [DvW-1:0]   div_q, div_d;
  logic [StepW-1:0] step_q, step_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [PosW-1:0]  out_pos_q, out_pos_d;
  logic [IdxW-1:0]  out_idx_q, out_idx_d;
  logic             out_final_q, out_final_d;

  // Store port
  logic             ram_we;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [SizeW-1:0] ram_rdata;

  // Combinational helpers
  logic [PosW-1:0]  free_space;
  logic [DvW1-1:0]  rem_sh;
  logic [DvW1-1:0]  trial;
  logic [PosW-1:0]  quot;
  logic [PosW-1:0]  half_sum;
  logic             out_free;
  logic             last_emit;

  // --------------------------------------------------------------------------
  // Child size store
  // --------------------------------------------------------------------------
  maa_ram #(
    .Width (SizeW),
    .Depth (MAX_CHILDREN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (in_i.child_size),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      container_q <= '0;
      spacing_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        maa_pkg::CFG_MODE:      mode_q      <= cfg_wdata_i[maa_pkg::MODE_W-1:0];
        maa_pkg::CFG_CONTAINER: container_q <= cfg_wdata_i[SizeW-1:0];
        maa_pkg::CFG_SPACING:   spacing_q   <= cfg_wdata_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Shared arithmetic terms
  // --------------------------------------------------------------------------
  assign free_space = room_q - PosW'(mul_q);
  // restoring divider step: shift in next dividend bit, trial subtract
  assign rem_sh     = {rem_q, quo_q[PosW-1]};
  assign trial      = rem_sh - DvW1'(div_q);
  // quotient with the sign of the room (divisor is always positive)
  assign quot       = room_q[PosW-1] ? (PosW'(0) - quo_q) : quo_q;
  // halving toward zero: add one before the shift when negative
  assign half_sum   = quot + PosW'(quot[PosW-1]);

  assign out_free   = !out_valid_q || out_o.ready;
  assign last_emit  = (CntW'(idx_q) + CntW'(1)) == count_q;

  // --------------------------------------------------------------------------
  // Sequencer: next state and datapath updates
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_o.ready;
    room_d      = room_q;
    mul_d       = mul_q;
    gap_d       = gap_q;
    pos_d       = pos_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    div_d       = div_q;
    step_d      = step_q;
    idx_d       = idx_q;
    out_pos_d   = out_pos_q;
    out_idx_d   = out_idx_q;
    out_final_d = out_final_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = idx_q;
    in_i.ready  = (state_q == maa_pkg::ST_LOAD);

    case (state_q)
      maa_pkg::ST_LOAD: begin
        if (in_i.valid) begin
          if (count_q < CntW'(MAX_CHILDREN)) begin
            ram_we  = 1'b1;
            count_d = count_q + CntW'(1);
            total_d = total_q + TotW'(in_i.child_size);
          end
          if (in_i.last_child) begin
            state_d = maa_pkg::ST_PREP;
          end
        end
      end

      maa_pkg::ST_PREP: begin
        room_d  = PosW'(container_q) - PosW'(total_q);
        mul_d   = MulW'(spacing_q) * MulW'(count_q - CntW'(1));
        state_d = maa_pkg::ST_FREE;
      end

      maa_pkg::ST_FREE: begin
        gap_d   = PosW'(spacing_q);
        pos_d   = '0;
        quo_d   = room_q[PosW-1] ? (PosW'(0) - room_q) : room_q;
        rem_d   = '0;
        step_d  = StepW'(maa_pkg::DIV_STEPS - 1);
        state_d = maa_pkg::ST_FETCH;
        case (mode_q)
          maa_pkg::MODE_END: begin
            pos_d = free_space[PosW-1] ? '0 : free_space;
          end
          maa_pkg::MODE_CENTER: begin
            pos_d = free_space[PosW-1] ? '0 : {1'b0, free_space[PosW-1:1]};
          end
          maa_pkg::MODE_BETWEEN: begin
            if (count_q == CntW'(1)) begin
              gap_d = '0;
            end else begin
              div_d   = DvW'(count_q) - DvW'(1);
              state_d = maa_pkg::ST_DIV;
            end
          end
          maa_pkg::MODE_AROUND: begin
            div_d   = DvW'(count_q);
            state_d = maa_pkg::ST_DIV;
          end
          maa_pkg::MODE_EVENLY: begin
            div_d   = DvW'(count_q) + DvW'(1);
            state_d = maa_pkg::ST_DIV;
          end
          default: ;
        endcase
      end

      maa_pkg::ST_DIV: begin
        quo_d = {quo_q[PosW-2:0], ~trial[DvW]};
        rem_d = trial[DvW] ? rem_sh[DvW-1:0] : trial[DvW-1:0];
        if (step_q == '0) begin
          state_d = maa_pkg::ST_GAP;
        end else begin
          step_d = step_q - StepW'(1);
        end
      end

      maa_pkg::ST_GAP: begin
        gap_d = quot;
        case (mode_q)
          maa_pkg::MODE_AROUND: pos_d = {half_sum[PosW-1], half_sum[PosW-1:1]};
          maa_pkg::MODE_EVENLY: pos_d = quot;
          default:              pos_d = '0;
        endcase
        state_d = maa_pkg::ST_FETCH;
      end

      maa_pkg::ST_FETCH: begin
        idx_d     = '0;
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_d   = maa_pkg::ST_EMIT;
      end

      maa_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pos_d   = pos_q;
          out_idx_d   = IdxW'(idx_q);
          out_final_d = last_emit;
          pos_d       = pos_q + PosW'(ram_rdata) + gap_q;
          if (last_emit) begin
            count_d = '0;
            total_d = '0;
            state_d = maa_pkg::ST_LOAD;
          end else begin
            // prefetch the next size while this beat goes out
            idx_d     = idx_q + AddrW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q + AddrW'(1);
          end
        end
      end

      default: state_d = maa_pkg::ST_LOAD;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= maa_pkg::ST_LOAD;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    room_q      <= room_d;
    mul_q       <= mul_d;
    gap_q       <= gap_d;
    pos_q       <= pos_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    div_q       <= div_d;
    step_q      <= step_d;
    idx_q       <= idx_d;
    out_pos_q   <= out_pos_d;
    out_idx_q   <= out_idx_d;
    out_final_q <= out_final_d;
  end

  // Output beat
  assign out_o.valid       = out_valid_q;
  assign out_o.position    = out_pos_q;
  assign out_o.child_index = out_idx_q;
  assign out_o.final_flag  = out_final_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Leaving the emit loop always hands over the flagged beat and a clean list
  a_emit_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == maa_pkg::ST_EMIT |=>
      state_q == maa_pkg::ST_EMIT ||
      (state_q == maa_pkg::ST_LOAD && count_q == '0 && out_valid_q && out_final_q))
    else $error("emit loop left without final beat or with stale count");

  // The divider never runs on a zero divisor
  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == maa_pkg::ST_DIV |-> div_q != '0)
    else $error("division started with zero divisor");

  // A beat taken into a full store leaves the count at its limit
  a_full_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && count_q == CntW'(MAX_CHILDREN)) |=>
      count_q == CntW'(MAX_CHILDREN))
    else $error("full store changed its count");

endmodule
